// File: rtl/bvfd_pkg.sv
// shared types and constants of the 1-bit video frame decoder
// parse phases, sequencer states, framebuffer command and result words
// no dependencies
package bvfd_pkg;

	// stream frame type codes
	localparam logic [7:0] FT_DELTA  = 8'd1;
	localparam logic [7:0] FT_KEY    = 8'd2;
	localparam logic [7:0] FT_REPEAT = 8'd3;

	// request kinds on the input side
	localparam logic REQ_READ = 1'b1;

	// pixels per framebuffer byte and log2 of pixels per delta block
	localparam int PIX_PER_BYTE = 8;
	localparam int BLOCK_BITS   = 6;

	// run length that a count byte of zero stands for
	localparam logic [8:0] RUN_MAX = 9'd256;

	// parse phase of the compressed stream
	typedef enum logic [2:0] {
		PH_TYPE,
		PH_KEY_MARKER,
		PH_KEY_DATA,
		PH_KEY_COUNT,
		PH_KEY_PIXEL,
		PH_DELTA_BITMAP,
		PH_DELTA_MASK,
		PH_DELTA_PIXEL
	} phase_t;

	// decode sequencer states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_READ,
		CS_RUN,
		CS_DPIX,
		CS_WAIT_WR,
		CS_NEXT_ROW,
		CS_SCAN,
		CS_RESULT
	} ctrl_state_t;

	// framebuffer unit states
	typedef enum logic [2:0] {
		FB_CLEAR,
		FB_IDLE,
		FB_RD,
		FB_WR_LO,
		FB_WR_HI
	} fb_state_t;

	typedef enum logic {
		CMD_READ,
		CMD_WRITE
	} fb_kind_t;

	// framebuffer command: a byte read or a pixel-byte write of n pixels
	typedef struct packed {
		fb_kind_t   kind;
		logic [7:0] px;
		logic [3:0] n;
	} fb_cmd_t;

	// framebuffer status back to the sequencer
	typedef struct packed {
		logic       ready;
		logic       done;
		logic [7:0] rdata;
	} fb_stat_t;

	// one result word
	typedef struct packed {
		logic       frame_done;
		logic       stream_stopped;
		logic       read_valid;
		logic [7:0] read_data;
	} bvfd_res_t;

endpackage

// File: rtl/bitmap_video_frame_decoder.sv
// channel   dir  tvalid/tready  tdata (low bit first)                     tuser     tlast
// s_axis    in   word accepted  stream_byte[7:0] read_address[17:8] 0     req_type  -
// m_axis    out  word accepted  stream_stopped[0] read_data[8:1] 0        read_valid frame_done
//
// after reset the whole framebuffer is cleared, one byte a cycle; no input word is taken meanwhile
// one input word at a time: a byte with no pixel write goes straight to its result, a read
// reads one memory byte, and each framebuffer byte written takes a read then a write of
// the memory; a delta group that straddles two bytes reads and writes both of them
// delta frames step over each skipped row and each clear mask bit in turn
// each result sits in an output register, so the next word is taken while it waits
module bitmap_video_frame_decoder import bvfd_pkg::*; #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // stream_byte[7:0], read_address[17:8], zero fill
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // stream_stopped[0], read_data[8:1], zero fill
	output logic        m_axis_tuser,   // read_valid
	output logic        m_axis_tlast    // frame_done
);

	localparam int POS_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT + 8);

	logic             cmd_valid;
	fb_cmd_t          cmd;
	logic [POS_W-1:0] cmd_pos;
	fb_stat_t         fb_stat;
	logic             res_valid;
	logic             res_ready;
	bvfd_res_t        res;
	logic             out_valid_q;
	bvfd_res_t        out_q;

	bvfd_ctrl #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_byte   (s_axis_tdata[7:0]),
		.in_addr   (s_axis_tdata[17:8]),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pos   (cmd_pos),
		.fb_stat   (fb_stat),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	bvfd_fb_unit #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pos   (cmd_pos),
		.stat      (fb_stat)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.read_data, out_q.stream_stopped};
	assign m_axis_tuser  = out_q.read_valid;
	assign m_axis_tlast  = out_q.frame_done;

endmodule

// File: rtl/bvfd_fb_unit.sv
// framebuffer memory with read-modify-write of pixel bytes and a clearing pass
// one synchronous memory, one write and one read port, read data registered
// depends on bvfd_pkg
module bvfd_fb_unit import bvfd_pkg::*; #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            cmd_valid,
	input  fb_cmd_t                                         cmd,
	input  logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT+8)-1:0]   cmd_pos,
	output fb_stat_t                                        stat
);

	localparam int PIXELS      = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int STORE_BYTES = (PIXELS + 7) / 8;
	localparam int AW          = $clog2(STORE_BYTES);

	// pixel byte, msb first, lands bit-reversed and inverted
	function automatic logic [7:0] rev_inv(input logic [7:0] px);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = ~px[7-k];
		end
		return r;
	endfunction

	logic [7:0]  mem [STORE_BYTES];
	logic [7:0]  mem_q;

	fb_state_t   state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic [15:0] data_q;
	logic [15:0] mask_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          load;
	logic          done;
	logic [AW-1:0] cmd_addr;
	logic [AW-1:0] addr_hi;
	logic [7:0]    mask8;
	logic [15:0]   data16;
	logic [15:0]   mask16;

	// byte address, shifted pixel data and mask of an incoming write
	assign cmd_addr = AW'(cmd_pos >> 3);
	assign addr_hi  = addr_q + AW'(1);
	assign mask8    = 8'((9'd1 << cmd.n) - 9'd1);
	assign data16   = {8'b0, rev_inv(cmd.px)} << cmd_pos[2:0];
	assign mask16   = {8'b0, mask8} << cmd_pos[2:0];

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = addr_q;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		load    = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			FB_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = FB_IDLE;
				end
			end
			FB_IDLE: begin
				if (cmd_valid) begin
					rd_en   = 1'b1;
					rd_addr = cmd_addr;
					load    = 1'b1;
					state_d = (cmd.kind == CMD_READ) ? FB_RD : FB_WR_LO;
				end
			end
			FB_RD: begin
				done    = 1'b1;
				state_d = FB_IDLE;
			end
			FB_WR_LO: begin
				wr_en   = 1'b1;
				wr_data = (mem_q & ~mask_q[7:0]) | (data_q[7:0] & mask_q[7:0]);
				if (mask_q[15:8] != 8'b0) begin
					rd_en   = 1'b1;
					rd_addr = addr_hi;
					state_d = FB_WR_HI;
				end else begin
					done    = 1'b1;
					state_d = FB_IDLE;
				end
			end
			FB_WR_HI: begin
				wr_en   = 1'b1;
				wr_addr = addr_hi;
				wr_data = (mem_q & ~mask_q[15:8]) | (data_q[15:8] & mask_q[15:8]);
				done    = 1'b1;
				state_d = FB_IDLE;
			end
			default: begin
				state_d = FB_IDLE;
			end
		endcase
	end

	// control registers, clearing pass starts at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FB_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FB_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= cmd_addr;
			data_q <= data16;
			mask_q <= mask16;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	assign stat.ready = (state_q == FB_IDLE);
	assign stat.done  = done;
	assign stat.rdata = mem_q;

endmodule

// File: rtl/bvfd_ctrl.sv
// stream parser and decode sequencer: frame types, key runs, delta row and mask walk
// issues pixel-byte writes and reads to the framebuffer unit, one at a time
// depends on bvfd_pkg
module bvfd_ctrl import bvfd_pkg::*; #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	output logic                                            in_ready,
	input  logic                                            in_kind,
	input  logic [7:0]                                      in_byte,
	input  logic [9:0]                                      in_addr,
	output logic                                            cmd_valid,
	output fb_cmd_t                                         cmd,
	output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT+8)-1:0]   cmd_pos,
	input  fb_stat_t                                        fb_stat,
	output logic                                            res_valid,
	output bvfd_res_t                                       res,
	input  logic                                            res_ready
);

	localparam int PIXELS      = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int STORE_BYTES = (PIXELS + 7) / 8;
	localparam int POS_W       = $clog2(PIXELS + 8);
	localparam int RC_W        = $clog2(FRAME_HEIGHT + 1);
	localparam int BB          = (FRAME_HEIGHT + 7) / 8;
	localparam int BIW         = (BB > 1) ? $clog2(BB) : 1;
	localparam logic [POS_W-1:0] PIX_POS = POS_W'(PIXELS);
	localparam logic [POS_W-1:0] W_POS   = POS_W'(FRAME_WIDTH);
	localparam logic [POS_W-1:0] STEP    = POS_W'(PIX_PER_BYTE);
	localparam logic [RC_W-1:0]  H_RC    = RC_W'(FRAME_HEIGHT);

	ctrl_state_t   state_q, state_d;
	phase_t        phase_q, phase_d;
	logic [7:0]    marker_q, marker_d;
	logic [8:0]    rl_q, rl_d;
	logic [POS_W-1:0] wp_q, wp_d;
	logic [RC_W-1:0]  rc_q, rc_d;
	logic [7:0]    gm_q, gm_d;
	logic          stopped_q, stopped_d;
	logic [7:0]    px_q, px_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [3:0]    n_q, n_d;
	logic          done_q, done_d;
	logic          rvalid_q, rvalid_d;
	logic [7:0]    rdata_q, rdata_d;
	logic [7:0]    bitmap_q [BB];
	logic          bm_we;

	logic             addr_ok;
	logic [POS_W-1:0] row_base;
	logic [POS_W-1:0] key_rem;
	logic [3:0]       key_n;
	logic [POS_W-1:0] delta_rem;
	logic [3:0]       delta_n;
	logic [POS_W-1:0] wp_step;
	logic [RC_W-1:0]  rc_inc;
	logic             row_marked;

	// address range, pixel positions and clipped pixel counts
	assign addr_ok   = 32'(in_addr) < STORE_BYTES;
	assign row_base  = POS_W'(rc_q) * W_POS;
	assign key_rem   = PIX_POS - wp_q;
	assign key_n     = (key_rem < STEP) ? key_rem[3:0] : 4'd8;
	assign delta_rem = W_POS - wp_q;
	assign delta_n   = (delta_rem < STEP) ? delta_rem[3:0] : 4'd8;
	assign wp_step   = wp_q + STEP;
	assign rc_inc    = rc_q + RC_W'(1);
	assign row_marked = bitmap_q[BIW'(rc_q >> 3)][3'd7 - rc_q[2:0]];

	// sequencer next state and outputs
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		marker_d  = marker_q;
		rl_d      = rl_q;
		wp_d      = wp_q;
		rc_d      = rc_q;
		gm_d      = gm_q;
		stopped_d = stopped_q;
		px_d      = px_q;
		pos_d     = pos_q;
		n_d       = n_q;
		done_d    = done_q;
		rvalid_d  = rvalid_q;
		rdata_d   = rdata_q;
		bm_we     = 1'b0;
		cmd_valid = 1'b0;
		cmd.kind  = CMD_WRITE;
		cmd.px    = px_q;
		cmd.n     = n_q;
		cmd_pos   = pos_q;
		in_ready  = (state_q == CS_IDLE) && fb_stat.ready;
		unique case (state_q)
			CS_IDLE: begin
				if (in_valid && in_ready) begin
					done_d   = 1'b0;
					rvalid_d = 1'b0;
					rdata_d  = 8'b0;
					state_d  = CS_RESULT;
					if (in_kind == REQ_READ) begin
						rvalid_d = 1'b1;
						if (addr_ok) begin
							cmd_valid = 1'b1;
							cmd.kind  = CMD_READ;
							cmd_pos   = POS_W'({in_addr, 3'b000});
							state_d   = CS_READ;
						end
					end else if (!stopped_q) begin
						unique case (phase_q)
							PH_TYPE: begin
								priority if (in_byte == FT_DELTA) begin
									rc_d    = '0;
									phase_d = PH_DELTA_BITMAP;
								end else if (in_byte == FT_KEY) begin
									phase_d = PH_KEY_MARKER;
								end else if (in_byte == FT_REPEAT) begin
									done_d = 1'b1;
								end else begin
									stopped_d = 1'b1;
								end
							end
							PH_KEY_MARKER: begin
								marker_d = in_byte;
								wp_d     = '0;
								phase_d  = PH_KEY_DATA;
							end
							PH_KEY_DATA: begin
								if (in_byte == marker_q) begin
									phase_d = PH_KEY_COUNT;
								end else begin
									px_d    = in_byte;
									rl_d    = 9'd1;
									state_d = CS_RUN;
								end
							end
							PH_KEY_COUNT: begin
								rl_d    = (in_byte == 8'b0) ? RUN_MAX : {1'b0, in_byte};
								phase_d = PH_KEY_PIXEL;
							end
							PH_KEY_PIXEL: begin
								px_d    = in_byte;
								state_d = CS_RUN;
							end
							PH_DELTA_BITMAP: begin
								bm_we = 1'b1;
								rc_d  = rc_inc;
								if (32'(rc_inc) >= BB) begin
									rc_d    = '0;
									wp_d    = '0;
									state_d = CS_NEXT_ROW;
								end
							end
							PH_DELTA_MASK: begin
								gm_d    = in_byte;
								state_d = CS_SCAN;
							end
							PH_DELTA_PIXEL: begin
								px_d    = in_byte;
								pos_d   = row_base + wp_q;
								n_d     = delta_n;
								state_d = CS_DPIX;
							end
						endcase
					end
				end
			end
			CS_READ: begin
				if (fb_stat.done) begin
					rdata_d = fb_stat.rdata;
					state_d = CS_RESULT;
				end
			end
			// key frame: one framebuffer byte per pass, clipped at frame end
			CS_RUN: begin
				if (rl_q != 9'b0 && wp_q < PIX_POS) begin
					cmd_valid = 1'b1;
					cmd.n     = key_n;
					cmd_pos   = wp_q;
					if (fb_stat.ready) begin
						wp_d    = wp_step;
						rl_d    = rl_q - 9'd1;
						state_d = CS_WAIT_WR;
					end
				end else begin
					if (wp_q >= PIX_POS) begin
						phase_d = PH_TYPE;
						done_d  = 1'b1;
					end else begin
						phase_d = PH_KEY_DATA;
					end
					state_d = CS_RESULT;
				end
			end
			// delta frame: one pixel group
			CS_DPIX: begin
				cmd_valid = 1'b1;
				if (fb_stat.ready) begin
					wp_d    = wp_q + POS_W'(n_q);
					gm_d    = {gm_q[6:0], 1'b0};
					state_d = CS_WAIT_WR;
				end
			end
			CS_WAIT_WR: begin
				if (fb_stat.done) begin
					if (phase_q == PH_DELTA_PIXEL) begin
						if (wp_q >= W_POS || wp_q[BLOCK_BITS-1:0] == '0) begin
							state_d = CS_NEXT_ROW;
						end else begin
							state_d = CS_SCAN;
						end
					end else begin
						state_d = CS_RUN;
					end
				end
			end
			// skip to the next marked row, one row per cycle
			CS_NEXT_ROW: begin
				if (rc_q >= H_RC) begin
					phase_d = PH_TYPE;
					done_d  = 1'b1;
					state_d = CS_RESULT;
				end else if (wp_q >= W_POS || !row_marked) begin
					rc_d = rc_inc;
					wp_d = '0;
				end else begin
					phase_d = PH_DELTA_MASK;
					state_d = CS_RESULT;
				end
			end
			// walk the group mask, one bit per cycle
			CS_SCAN: begin
				if (wp_q < W_POS) begin
					if (gm_q[7]) begin
						phase_d = PH_DELTA_PIXEL;
						state_d = CS_RESULT;
					end else begin
						wp_d = wp_step;
						gm_d = {gm_q[6:0], 1'b0};
						if (wp_step[BLOCK_BITS-1:0] == '0) begin
							state_d = CS_NEXT_ROW;
						end
					end
				end else begin
					state_d = CS_NEXT_ROW;
				end
			end
			CS_RESULT: begin
				if (res_ready) begin
					state_d = CS_IDLE;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CS_IDLE;
			phase_q   <= PH_TYPE;
			marker_q  <= '0;
			rl_q      <= '0;
			wp_q      <= '0;
			rc_q      <= '0;
			gm_q      <= '0;
			stopped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			marker_q  <= marker_d;
			rl_q      <= rl_d;
			wp_q      <= wp_d;
			rc_q      <= rc_d;
			gm_q      <= gm_d;
			stopped_q <= stopped_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		px_q     <= px_d;
		pos_q    <= pos_d;
		n_q      <= n_d;
		done_q   <= done_d;
		rvalid_q <= rvalid_d;
		rdata_q  <= rdata_d;
	end

	// row bitmap of the current delta frame
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bitmap_q[BIW'(rc_q)] <= in_byte;
		end
	end

	assign res_valid          = (state_q == CS_RESULT);
	assign res.frame_done     = done_q;
	assign res.stream_stopped = stopped_q;
	assign res.read_valid     = rvalid_q;
	assign res.read_data      = rdata_q;

endmodule
